// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define APS_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

`define APS_ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) else $error(msg);

`else

`define APS_ASSERT(lbl, clk_s, rst_s, prop, msg)

`define APS_ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg)

`endif

`endif

// ===== design/aps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aps_pkg;

  localparam int TASK_W = 4;
  localparam int PRIO_W = 6;
  localparam int QCNT_W = 5;

  typedef logic signed [PRIO_W-1:0] prio_t;

  localparam prio_t PRIO_MIN = -6'sd20;
  localparam prio_t PRIO_MAX = 6'sd20;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_PICK  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_RANGE  = 2'd2,
    ST_REJECT = 2'd3
  } status_e;

  // One queue position: the slot id with its static and dynamic priority.
  // The same shape carries the running winner of a scan, where valid means found.
  typedef struct packed {
    logic              valid;
    logic [TASK_W-1:0] slot;
    prio_t             stat;
    prio_t             dyn;
  } entry_t;

  typedef struct packed {
    prio_t stat;
    prio_t dyn;
  } prio_pair_t;

  typedef struct packed {
    logic age;
    logic set;
    logic load;
    logic remove;
  } cell_op_t;

endpackage

`default_nettype wire

// ===== design/aps_slot_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aps_slot_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      rd_en,
  input  wire [ADDR_W-1:0]         rd_addr,
  output aps_pkg::prio_pair_t      rd_data,
  input  wire                      wr_en,
  input  wire [ADDR_W-1:0]         wr_addr,
  input  aps_pkg::prio_pair_t      wr_data
);

  aps_pkg::prio_pair_t mem [DEPTH];
  aps_pkg::prio_pair_t rd_q;
  logic [DEPTH-1:0]    written;
  logic                rd_written_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // A slot that was never written reads as both priorities zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written      <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written_q <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_written_q ? rd_q : '0;

endmodule

`default_nettype wire

// ===== design/aps_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aps_cell #(
  parameter int IDX_W = 4,
  parameter int POS   = 0
) (
  input  wire                  clk,
  input  wire                  rst,
  input  aps_pkg::cell_op_t    op,
  input  aps_pkg::entry_t      bcast,
  input  aps_pkg::entry_t      nbr,
  output aps_pkg::entry_t      ent,
  input  aps_pkg::entry_t      scan_in,
  input  wire [IDX_W-1:0]      scan_idx_in,
  output aps_pkg::entry_t      scan_out,
  output logic [IDX_W-1:0]     scan_idx_out
);

  logic take;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (op.remove) begin
      ent <= nbr;
    end else if (op.load) begin
      ent <= bcast;
    end else if (op.age && ent.valid && (ent.dyn > aps_pkg::PRIO_MIN)) begin
      ent.dyn <= ent.dyn - 6'sd1;
    end else if (op.set && ent.valid && (ent.slot == bcast.slot)) begin
      ent.stat <= bcast.stat;
      ent.dyn  <= bcast.dyn;
    end
  end

  // Strictly lower wins, so on a tie the earlier queue position keeps the lead.
  assign take = ent.valid && (!scan_in.valid || (ent.dyn < scan_in.dyn));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else if (take) begin
      scan_out     <= ent;
      scan_idx_out <= IDX_W'(POS);
    end else begin
      scan_out     <= scan_in;
      scan_idx_out <= scan_idx_in;
    end
  end

endmodule

`default_nettype wire

// ===== design/aps_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module aps_chain #(
  parameter int N     = 16,
  parameter int IDX_W = 4
) (
  input  wire                  clk,
  input  wire                  rst,
  input  aps_pkg::cell_op_t    op,
  input  aps_pkg::entry_t      bcast,
  input  wire [IDX_W-1:0]      load_idx,
  input  wire [IDX_W-1:0]      remove_idx,
  output aps_pkg::entry_t      head,
  output aps_pkg::entry_t      best,
  output logic [IDX_W-1:0]     best_idx
);

  aps_pkg::entry_t ents  [N];
  aps_pkg::entry_t scans [N];
  logic [IDX_W-1:0] sidx [N];
  logic [N-1:0]     valid_vec;

  for (genvar i = 0; i < N; i++) begin : g_cell
    aps_pkg::cell_op_t cop;
    aps_pkg::entry_t   nbr;
    aps_pkg::entry_t   sin;
    logic [IDX_W-1:0]  sin_idx;

    assign cop.age    = op.age;
    assign cop.set    = op.set;
    assign cop.load   = op.load && (IDX_W'(i) == load_idx);
    // Every position at or behind the removed one takes its neighbor's entry.
    assign cop.remove = op.remove && (IDX_W'(i) >= remove_idx);

    if (i == N - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = ents[i+1];
    end

    if (i == 0) begin : g_first
      assign sin     = '0;
      assign sin_idx = '0;
    end else begin : g_rest
      assign sin     = scans[i-1];
      assign sin_idx = sidx[i-1];
    end

    aps_cell #(
      .IDX_W (IDX_W),
      .POS   (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .op           (cop),
      .bcast        (bcast),
      .nbr          (nbr),
      .ent          (ents[i]),
      .scan_in      (sin),
      .scan_idx_in  (sin_idx),
      .scan_out     (scans[i]),
      .scan_idx_out (sidx[i])
    );

    assign valid_vec[i] = ents[i].valid;
  end

  assign head     = ents[0];
  assign best     = scans[N-1];
  assign best_idx = sidx[N-1];

  `APS_ASSERT_NEVER(a_no_holes, clk, rst, ((valid_vec + 1'b1) & valid_vec) != '0, "queue has a gap")
  `APS_ASSERT(a_age_keeps_occupancy, clk, rst, op.age |=> (valid_vec == $past(valid_vec)), "aging changed occupancy")
  `APS_ASSERT(a_load_adds_one, clk, rst, (op.load && !op.remove) |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1), "load did not add one entry")

endmodule

`default_nettype wire

// ===== design/aging_priority_scheduler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Channel   Dir  Fields (tdata from bit 0 up)                         tuser
// s_axis    in   task_req[3:0], priority_req[9:4], zero pad [15:10]  command[1:0]
// m_axis    out  chosen_task[3:0], priority_out[9:4],                status[1:0]
//                queue_count[14:10], zero pad [15]
//
// Enqueue, set, query and a pick on zero or one queued task register their result from the
// look state once the output register is free. A pick with two or more queued tasks first
// ages all cells, ripples the winner search down the row, then removes the winner once the
// output register is free. The block takes its next word at the edge after a result is
// registered; a finished result waits in the output register, and the next one is held.
// Reset (rst, synchronous) empties the queue and clears all priorities to zero.

module aging_priority_scheduler_core #(
  parameter int MAX_TASKS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire [15:0]  s_tdata,   // task_req[3:0], priority_req[9:4]
  input  wire [1:0]   s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // chosen_task[3:0], priority_out[9:4], queue_count[14:10]
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int SLOT_W = $clog2(MAX_TASKS);
  localparam int IDX_W  = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int QW     = aps_pkg::QCNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                       state, state_next;
  aps_pkg::cmd_e                cmd_q;
  logic [aps_pkg::TASK_W-1:0]   task_q;
  aps_pkg::prio_t               req_q;
  logic                         dup_q;
  logic [CNT_W-1:0]             count, count_next;
  logic [IDX_W-1:0]             scan_cnt;
  logic [MAX_TASKS-1:0]         is_queued;

  logic [aps_pkg::TASK_W-1:0]   out_task;
  aps_pkg::status_e             out_status;
  aps_pkg::prio_t               out_prio;
  logic [QW-1:0]                out_count;

  logic                         accept, out_free, slot_ok, emit;
  logic [aps_pkg::TASK_W-1:0]   e_task;
  aps_pkg::status_e             e_status;
  aps_pkg::prio_t               e_prio;

  aps_pkg::cell_op_t            op;
  aps_pkg::entry_t              bcast, head, best;
  logic [IDX_W-1:0]             load_idx, remove_idx, best_idx;

  logic                         mem_wr;
  logic [SLOT_W-1:0]            mem_wr_addr, q_addr;
  aps_pkg::prio_pair_t          mem_wr_data, rd;
  logic                         q_set, q_clr;

  logic [aps_pkg::TASK_W-1:0]   in_task;

  assign in_task  = s_tdata[3:0];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign slot_ok  = int'(task_q) < MAX_TASKS;

  aps_slot_mem #(
    .DEPTH  (MAX_TASKS),
    .ADDR_W (SLOT_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (SLOT_W'(in_task)),
    .rd_data (rd),
    .wr_en   (mem_wr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  aps_chain #(
    .N     (MAX_TASKS),
    .IDX_W (IDX_W)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .bcast      (bcast),
    .load_idx   (load_idx),
    .remove_idx (remove_idx),
    .head       (head),
    .best       (best),
    .best_idx   (best_idx)
  );

  always_comb begin
    state_next  = state;
    emit        = 1'b0;
    e_task      = task_q;
    e_status    = aps_pkg::ST_OK;
    e_prio      = rd.stat;
    count_next  = count;
    op          = '0;
    load_idx    = IDX_W'(count);
    remove_idx  = '0;
    bcast.valid = 1'b1;
    bcast.slot  = task_q;
    bcast.stat  = rd.stat;
    bcast.dyn   = rd.dyn;
    mem_wr      = 1'b0;
    mem_wr_addr = SLOT_W'(task_q);
    mem_wr_data = rd;
    q_set       = 1'b0;
    q_clr       = 1'b0;
    q_addr      = SLOT_W'(task_q);

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_LOOK;
        end
      end

      S_LOOK: begin
        if ((cmd_q == aps_pkg::CMD_PICK) && (count > CNT_W'(1))) begin
          op.age     = 1'b1;
          state_next = S_SCAN;
        end else if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (cmd_q == aps_pkg::CMD_PICK) begin
            if (count == '0) begin
              e_task   = '0;
              e_status = aps_pkg::ST_EMPTY;
              e_prio   = '0;
            end else begin
              // A lone task leaves with its priorities as they are.
              op.remove   = 1'b1;
              e_task      = head.slot;
              e_prio      = head.stat;
              count_next  = count - CNT_W'(1);
              mem_wr      = 1'b1;
              mem_wr_addr = SLOT_W'(head.slot);
              mem_wr_data.stat = head.stat;
              mem_wr_data.dyn  = head.dyn;
              q_clr       = 1'b1;
              q_addr      = SLOT_W'(head.slot);
            end
          end else if (!slot_ok) begin
            e_status = aps_pkg::ST_REJECT;
            e_prio   = '0;
          end else begin
            case (cmd_q)
              aps_pkg::CMD_ENQ: begin
                if (dup_q || (count == CNT_W'(MAX_TASKS))) begin
                  e_status = aps_pkg::ST_REJECT;
                end else begin
                  op.load    = 1'b1;
                  count_next = count + CNT_W'(1);
                  q_set      = 1'b1;
                end
              end
              aps_pkg::CMD_SET: begin
                if ((req_q < aps_pkg::PRIO_MIN) || (req_q > aps_pkg::PRIO_MAX)) begin
                  e_status = aps_pkg::ST_RANGE;
                end else begin
                  op.set           = 1'b1;
                  bcast.stat       = req_q;
                  bcast.dyn        = req_q;
                  mem_wr           = 1'b1;
                  mem_wr_data.stat = req_q;
                  mem_wr_data.dyn  = req_q;
                  e_prio           = req_q;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      S_SCAN: begin
        if (scan_cnt == IDX_W'(MAX_TASKS - 1)) begin
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          emit             = 1'b1;
          state_next       = S_IDLE;
          op.remove        = 1'b1;
          remove_idx       = best_idx;
          e_task           = best.slot;
          e_prio           = best.stat;
          count_next       = count - CNT_W'(1);
          mem_wr           = 1'b1;
          mem_wr_addr      = SLOT_W'(best.slot);
          mem_wr_data.stat = best.stat;
          mem_wr_data.dyn  = best.stat;
          q_clr            = 1'b1;
          q_addr           = SLOT_W'(best.slot);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= aps_pkg::cmd_e'(s_tuser);
      task_q <= in_task;
      req_q  <= $signed(s_tdata[9:4]);
      dup_q  <= is_queued[SLOT_W'(in_task)];
    end
    if (emit) begin
      out_task   <= e_task;
      out_status <= e_status;
      out_prio   <= e_prio;
      out_count  <= QW'(count_next);
    end
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      count     <= '0;
      is_queued <= '0;
      scan_cnt  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (q_set) begin
        is_queued[q_addr] <= 1'b1;
      end else if (q_clr) begin
        is_queued[q_addr] <= 1'b0;
      end
      if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + IDX_W'(1);
      end else begin
        scan_cnt <= '0;
      end
    end
  end

  assign m_tdata = {1'b0, out_count, out_prio, out_task};
  assign m_tuser = out_status;

  `APS_ASSERT(a_one_at_a_time, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "took a word while busy")
  `APS_ASSERT(a_count_matches, clk, rst, $countones(is_queued) == int'(count), "queued flags disagree with count")
  `APS_ASSERT(a_winner_found, clk, rst, (state == S_FINISH) |-> best.valid, "scan ended without a winner")
  `APS_ASSERT(a_count_on_emit, clk, rst, (count != $past(count)) |-> $past(emit), "count moved without a result")

endmodule

`default_nettype wire
